/* src/sgn_pkg.sv */
package sgn_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned TBL_DEPTH = 1 << BYTE_W;

    // One write into the substitution memory
    typedef struct packed {
        logic              we;
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } sgn_wr_t;

    // Gate network: bit i of u is input U[i]; output S[j] lands on bit 7-j.
    function automatic logic [BYTE_W-1:0] sgn_network(input logic [BYTE_W-1:0] u);
        logic b0, b1, b2, b3, b4, b5, b6, b7, nb0, nb6;
        logic l0, l1, l2, l3, l4, l6, l7, l8, l9, l10, l11, l12, l13, l14;
        logic l15, l16, l18, l19, l20;
        logic g0, g1, g2, g3, g4, g5, g6, g7, g8, g9, g10, g11, g12, g13, g14;
        logic g15, g16, g17, g18, g19, g20, g21, g22, g23, g24, g25, g26, g27;
        logic g28, g29, g30, g31, g32, g33, g34, g35, g36, g37, g38, g39, g40;
        logic g41, g42, g43, g44, g45, g46, g47, g48, g49;
        logic g50, g51, g52, g53, g54, g55, g56, g57, g58, g59, g60, g61;
        logic g62, g63, g64, g65, g66, g67, g68, g69, g70, g71;
        logic c0, c1, c2, c3, c4, c5, c6, c7, c8, c9, c10, c11, c12, c13;
        logic c14, c15, c16, c17;
        logic r0, r1, r2, r3, r4, r5, r6, r7;
        b0 = u[0]; b1 = u[1]; b2 = u[2]; b3 = u[3];
        b4 = u[4]; b5 = u[5]; b6 = u[6]; b7 = u[7];
        nb0 = ~b0;
        nb6 = ~b6;

        // top linear layer
        l12 = b2 ^ b6;
        l10 = l12 ^ b1;
        g0  = b3 ^ b5;
        l1  = g0 ^ b0;
        l3  = b1 ^ l1;
        l9  = l3 ^ b3;
        l4  = nb0 ^ l9;
        l19 = g0 ^ b6;
        g1  = b4 ^ b7;
        l8  = g1 ^ b5;
        l0  = l8 ^ l1;
        l2  = l0 ^ l12;
        l15 = l2 ^ l3;
        l16 = l15 ^ nb6;
        l11 = l16 ^ l9;
        g2  = l1 ^ b7;
        l7  = g2 ^ l11;
        l6  = l7 ^ l16;
        l14 = l7 ^ nb0;
        l13 = l14 ^ l11;
        l18 = l7 ^ l3;
        g3  = b2 ^ b7;
        l20 = g3 ^ g0;

        // nonlinear middle
        g4  = l7 & l3;
        g5  = l15 & l16;
        g6  = l6 & l2;
        g7  = l13 & l12;
        g8  = l11 & l10;
        g9  = l14 & b1;
        g10 = nb0 & l1;
        g11 = l9 & l8;
        g12 = l4 & l0;
        g13 = g12 ^ g10;
        g14 = g13 ^ g6;
        g15 = g11 ^ g10;
        g16 = g4 ^ g15;
        g17 = g5 ^ g14;
        g18 = g9 ^ g17;
        g19 = g7 ^ g18;
        g20 = l20 ^ g19;
        g21 = g6 ^ g16;
        g22 = g9 ^ g21;
        g23 = g8 ^ g22;
        g24 = l19 ^ g23;
        g25 = g4 ^ g14;
        g26 = l18 ^ g25;
        g27 = g5 ^ g16;
        g28 = nb6 ^ g27;
        g29 = g24 ^ g20;
        g30 = g24 & g28;
        g31 = g30 ^ g26;
        g32 = g29 & g31;
        g33 = g32 ^ g20;
        g34 = g28 ^ g26;
        g35 = g30 ^ g20;
        g36 = g34 & g35;
        g37 = g36 ^ g26;
        g38 = g37 ^ g28;
        g39 = g37 ^ g31;
        g40 = g26 & g39;
        g41 = g38 ^ g40;
        g42 = g40 ^ g31;
        g43 = g33 & g42;
        g44 = g29 ^ g43;
        g45 = g41 ^ g37;
        g46 = g33 ^ g37;
        g47 = g44 ^ g41;
        g48 = g47 ^ g46;
        g49 = g44 ^ g33;

        c17 = g37 & l3;
        c16 = g45 & l15;
        c15 = g41 & l2;
        c14 = g48 & l10;
        c13 = g47 & l12;
        c12 = g46 & b1;
        c11 = g33 & l1;
        c10 = g49 & l8;
        c9  = g44 & l0;
        c8  = g37 & l7;
        c7  = g45 & l16;
        c6  = g41 & l6;
        c5  = g48 & l11;
        c4  = g47 & l13;
        c3  = g46 & l14;
        c2  = g33 & nb0;
        c1  = g49 & l9;
        c0  = g44 & l4;

        // bottom linear layer
        g50 = c16 ^ c17;
        g51 = c16 ^ c15;
        g52 = c13 ^ c12;
        g53 = c14 ^ c12;
        g54 = c10 ^ c11;
        g55 = c10 ^ c9;
        g56 = c7 ^ c8;
        g57 = c7 ^ c6;
        g58 = c4 ^ c3;
        g59 = c5 ^ c3;
        g60 = c1 ^ c2;
        g61 = c1 ^ c0;
        r4  = g53 ^ g51;
        g62 = g52 ^ g54;
        g63 = ~g60;
        g64 = g63 ^ g58;
        g65 = g52 ^ g50;
        r3  = g65 ^ g64;
        g66 = g61 ^ g57;
        r5  = g66 ^ g62;
        r7  = g66 ^ r3;
        g67 = g62 ^ g56;
        r2  = g67 ^ g58;
        g68 = g64 ^ r4;
        r6  = g68 ^ g62;
        g69 = g55 ^ g51;
        r0  = ~g69;
        g70 = g59 ^ g57;
        g71 = g68 ^ r2;
        r1  = g71 ^ g70;

        return {r0, r1, r2, r3, r4, r5, r6, r7};
    endfunction

endpackage

/* src/sgn_fill.sv */
module sgn_fill (
    input  logic            clk,
    input  logic            rst_n,
    output sgn_pkg::sgn_wr_t wr,
    output logic            done
);
    import sgn_pkg::*;

    logic [BYTE_W-1:0] idx_reg;
    logic [BYTE_W-1:0] idx_next;
    logic              done_reg;
    logic              done_next;

    // sweep every address once after reset
    always_comb
    begin
        idx_next  = idx_reg;
        done_next = done_reg;
        if (!done_reg)
        begin
            idx_next = idx_reg + BYTE_W'(1);
            if (idx_reg == BYTE_W'(TBL_DEPTH - 1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            done_reg <= done_next;
        end
    end

    // entry value straight from the gate network
    always_comb
    begin
        wr.we   = !done_reg;
        wr.addr = idx_reg;
        wr.data = sgn_network(idx_reg);
    end

    assign done = done_reg;

endmodule

/* src/sgn_mem.sv */
module sgn_mem (
    input  logic                      clk,
    input  sgn_pkg::sgn_wr_t          wr,
    input  logic                      re,
    input  logic [sgn_pkg::BYTE_W-1:0] raddr,
    output logic [sgn_pkg::BYTE_W-1:0] rdata
);
    import sgn_pkg::*;

    logic [BYTE_W-1:0] mem [TBL_DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/sbox_gate_network_8bit.sv */
// Channel | Signals                      | Direction
// --------+------------------------------+----------
// input   | in_valid, in_stall, in_byte  | in / out / in
// output  | out_valid, out_stall, out_byte | out / in / out
//
// One byte per cycle unless stalled; each byte passes the memory read and output registers.
// After reset a pass over all 256 addresses writes the substitution memory from the
// gate network; in_stall stays high throughout it.
// The read stage and the output register form a two-entry pipeline, so input is
// taken while a result waits under out_stall until both stages are full.
module sbox_gate_network_8bit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [sgn_pkg::BYTE_W-1:0] in_byte,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [sgn_pkg::BYTE_W-1:0] out_byte
);
    import sgn_pkg::*;

    sgn_wr_t           wr;
    logic              fill_done;
    logic              rd_en;
    logic [BYTE_W-1:0] rd_data;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_free;
    logic              s1_move;
    logic              in_take;

    sgn_fill u_fill (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .done  (fill_done)
    );

    sgn_mem u_mem (
        .clk   (clk),
        .wr    (wr),
        .re    (rd_en),
        .raddr (in_byte),
        .rdata (rd_data)
    );

    // pipeline advance
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_stall = !(fill_done && (!s1_valid_reg || out_free));
    assign in_take  = in_valid && !in_stall;
    assign rd_en    = in_take;

    always_comb
    begin
        s1_valid_next  = in_take || (s1_valid_reg && !out_free);
        out_valid_next = s1_move || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output data register
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_byte_reg <= rd_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

`ifndef NO_ASSERTIONS
    // no transaction enters before the memory is filled
    a_no_take_during_fill: assert property (@(posedge clk) disable iff (!rst_n)
        !fill_done |-> in_stall)
        else $error("input accepted during memory fill");

    // an accepted transaction occupies the read stage next cycle
    a_take_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> s1_valid_reg)
        else $error("accepted transaction lost from read stage");

    // a blocked read stage keeps its data
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> (s1_valid_reg && $stable(rd_data)))
        else $error("read stage data changed while blocked");
`endif

endmodule
